// ----- rtl/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by ffha_ctrl, ffha_dp and the top level.
package ffha_pkg;

  localparam int ALLOC_W     = 12;
  localparam int ADDR_W      = 32;
  localparam int FAIL_W      = 16;
  localparam int CNT_OUT_W   = 11;
  localparam int BYTE_OUT_W  = 13;
  localparam int LSTART_W    = 12;
  localparam int CFG_IDX_W   = 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_LARGE_START  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_EV,
    ST_FIN,
    ST_SPLIT,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic rd;
    logic ev;
    logic fin;
    logic split;
    logic free_rd;
    logic free_wr;
    logic load_out;
  } ffha_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mode_free;
    logic hdr_end;
    logic found;
    logic need_split;
    logic free_bad;
  } ffha_sts_t;

endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// After reset the block initializes its header memory (one word per cycle)
// and takes no item meanwhile; configuration writes are accepted at all
// times. An allocate item passes START, then one read of the header memory
// and one evaluate step for each header of its walk, counting the one that
// finds the fitting block or the end of the heap; a success then passes FIN,
// plus SPLIT when the chosen block is split, and every item ends in DONE. A
// free item passes START, FREE_RD, FREE_WR and DONE, and skips FREE_WR when
// the address is unaligned or falls outside the heap. One item is in work at
// a time. The next item is accepted while the previous result waits to be
// taken, and its DONE state stalls until that result is taken.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES  = 4096,
  parameter int SMALL_LIMIT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [ALLOC_W-1:0]    in_alloc_size,
  input  logic [ADDR_W-1:0]     in_free_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic [ADDR_W-1:0]     out_address,
  output logic [FAIL_W-1:0]     out_failure_count,
  output logic [CNT_OUT_W-1:0]  out_block_total,
  output logic [CNT_OUT_W-1:0]  out_free_blocks,
  output logic [BYTE_OUT_W-1:0] out_bytes_used,
  output logic [BYTE_OUT_W-1:0] out_peak_bytes_used,
  output logic [CNT_OUT_W-1:0]  out_peak_block_total,
  output logic [BYTE_OUT_W-1:0] out_high_water,
  output logic [BYTE_OUT_W-1:0] out_bytes_free
);

  ffha_cmd_t cmd;
  ffha_sts_t sts;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffha_dp #(
    .HEAP_BYTES  (HEAP_BYTES),
    .SMALL_LIMIT (SMALL_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_mode              (in_mode),
    .in_alloc_size        (in_alloc_size),
    .in_free_address      (in_free_address),
    .out_ok               (out_ok),
    .out_address          (out_address),
    .out_failure_count    (out_failure_count),
    .out_block_total      (out_block_total),
    .out_free_blocks      (out_free_blocks),
    .out_bytes_used       (out_bytes_used),
    .out_peak_bytes_used  (out_peak_bytes_used),
    .out_peak_block_total (out_peak_block_total),
    .out_high_water       (out_high_water),
    .out_bytes_free       (out_bytes_free)
  );

endmodule

// ----- rtl/ffha_ctrl.sv -----
// Controller FSM for the first-fit heap allocator.
// Depends on ffha_pkg; drives ffha_dp through ffha_cmd_t.
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ffha_cmd_t cmd,
  input  ffha_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_START;
        end
      end
      ST_START: begin
        state_nxt = sts.mode_free ? ST_FREE_RD : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        cmd.ev = 1'b1;
        if (sts.hdr_end)    state_nxt = ST_DONE;
        else if (sts.found) state_nxt = ST_FIN;
        else                state_nxt = ST_RD;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.need_split ? ST_SPLIT : ST_DONE;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = sts.free_bad ? ST_DONE : ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/ffha_dp.sv -----
// Datapath of the first-fit heap allocator: header memory, walk registers,
// statistics and result registers. Depends on ffha_pkg; commanded by ffha_ctrl.
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES  = 4096,
  parameter int SMALL_LIMIT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffha_cmd_t             cmd,
  output ffha_sts_t             sts,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  logic                  in_mode,
  input  logic [ALLOC_W-1:0]    in_alloc_size,
  input  logic [ADDR_W-1:0]     in_free_address,
  output logic                  out_ok,
  output logic [ADDR_W-1:0]     out_address,
  output logic [FAIL_W-1:0]     out_failure_count,
  output logic [CNT_OUT_W-1:0]  out_block_total,
  output logic [CNT_OUT_W-1:0]  out_free_blocks,
  output logic [BYTE_OUT_W-1:0] out_bytes_used,
  output logic [BYTE_OUT_W-1:0] out_peak_bytes_used,
  output logic [CNT_OUT_W-1:0]  out_peak_block_total,
  output logic [BYTE_OUT_W-1:0] out_high_water,
  output logic [BYTE_OUT_W-1:0] out_bytes_free
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int AW   = $clog2(HEAP_WORDS);
  localparam int SBW  = $clog2(HEAP_BYTES + 1);
  localparam int HW   = SBW + 1;
  localparam int BW   = (SBW > ALLOC_W + 1) ? SBW : ALLOC_W + 1;
  localparam int CW   = $clog2(HEAP_WORDS + 1);
  localparam int PW0  = $clog2(HEAP_WORDS + 1);
  localparam int PW   = (PW0 > LSTART_W - 2) ? PW0 : LSTART_W - 2;
  localparam int EW   = PW + 3;

  // header memory: {in_use, size}
  logic [HW-1:0] mem [HEAP_WORDS];
  logic [HW-1:0] rd_data_r;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [HW-1:0] wd;

  logic [ADDR_W-1:0]   base_r;
  logic [LSTART_W-1:0] large_r;
  logic [BW-1:0]       small_r;
  logic [FAIL_W-1:0]   fail_r;
  logic [CW-1:0]       blocks_r, freen_r, bpeak_r;
  logic [BW-1:0]       used_r, upeak_r, endm_r, fbytes_r;

  logic                mode_r;
  logic [BW-1:0]       needed_r;
  logic [PW-1:0]       pos_r;
  logic                oob_r;
  logic [AW-1:0]       chosen_r;
  logic [BW-1:0]       csize_r;
  logic                merging_r;
  logic [ADDR_W-1:0]   free_off_r;
  logic                ok_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [AW-1:0]       clr_idx_r;

  logic                o_ok_r;
  logic [ADDR_W-1:0]   o_addr_r;
  logic [FAIL_W-1:0]   o_fail_r;
  logic [CW-1:0]       o_blocks_r, o_freen_r, o_bpeak_r;
  logic [BW-1:0]       o_used_r, o_upeak_r, o_endm_r, o_fbytes_r;

  // accept-time values
  logic [BW-1:0] needed_a, start_a;
  assign needed_a = (BW'(in_alloc_size) + BW'(7)) & ~BW'(3);
  assign start_a  = (needed_a > BW'(SMALL_LIMIT)) ? BW'(large_r) : small_r;

  // header evaluation during the walk
  logic [SBW-1:0] h_size;
  logic           h_used, hdr_ok, found;
  logic [EW-1:0]  h_end;
  logic [BW-1:0]  sum, fit_sz;
  assign h_size = rd_data_r[SBW-1:0];
  assign h_used = rd_data_r[SBW];
  assign h_end  = {pos_r, 2'b00} + EW'(h_size);
  assign hdr_ok = !oob_r && (h_size != '0) && (h_size[1:0] == 2'b00)
                  && (h_end <= EW'(HEAP_BYTES));
  assign sum    = csize_r + BW'(h_size);
  assign fit_sz = merging_r ? sum : BW'(h_size);
  assign found  = hdr_ok && !h_used && (needed_r <= fit_sz);

  // finish of an allocation
  logic [BW-1:0] rem, taken;
  logic [BW:0]   used_sum, top;
  logic [BW-1:0] used_new;
  logic          need_split;
  logic [CW-1:0] blocks_inc;
  assign rem        = csize_r - needed_r;
  assign need_split = rem >= BW'(4);
  assign taken      = need_split ? needed_r : csize_r;
  assign used_sum   = {1'b0, used_r} + {1'b0, taken};
  assign used_new   = (used_sum > (BW + 1)'(HEAP_BYTES)) ? BW'(HEAP_BYTES) : used_sum[BW-1:0];
  assign top        = (BW + 1)'({chosen_r, 2'b00}) + {1'b0, taken};
  assign blocks_inc = (blocks_r >= CW'(HEAP_WORDS)) ? CW'(HEAP_WORDS) : blocks_r + 1'b1;

  // free
  logic          free_bad;
  logic [AW-1:0] free_idx;
  logic [BW:0]   fb_sum;
  assign free_bad = (free_off_r[1:0] != 2'b00) || (free_off_r >= ADDR_W'(HEAP_BYTES));
  assign free_idx = free_off_r[AW+1:2];
  assign fb_sum   = {1'b0, fbytes_r} + (BW + 1)'(h_size);

  assign sts.clr_last   = (clr_idx_r == AW'(HEAP_WORDS - 1));
  assign sts.mode_free  = (mode_r == MODE_FREE);
  assign sts.hdr_end    = !hdr_ok;
  assign sts.found      = found;
  assign sts.need_split = need_split;
  assign sts.free_bad   = free_bad;

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = chosen_r;
    wd = '0;
    if (cmd.clr) begin
      we = 1'b1;
      wa = clr_idx_r;
      wd = (clr_idx_r == '0) ? HW'(HEAP_BYTES) : '0;
    end else if (cmd.ev) begin
      we = hdr_ok && !h_used && merging_r;
      wd = {1'b0, sum[SBW-1:0]};
    end else if (cmd.fin) begin
      we = 1'b1;
      if (need_split) begin
        wa = chosen_r + AW'(needed_r >> 2);
        wd = {1'b0, rem[SBW-1:0]};
      end else begin
        wd = {1'b1, csize_r[SBW-1:0]};
      end
    end else if (cmd.split) begin
      we = 1'b1;
      wd = {1'b1, needed_r[SBW-1:0]};
    end else if (cmd.free_wr) begin
      we = 1'b1;
      wa = free_idx;
      wd = {1'b0, h_size};
    end
  end

  assign re = cmd.rd || (cmd.free_rd && !free_bad);
  assign ra = cmd.rd ? pos_r[AW-1:0] : free_idx;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      large_r   <= '0;
      small_r   <= '0;
      fail_r    <= '0;
      blocks_r  <= CW'(1);
      freen_r   <= CW'(1);
      bpeak_r   <= CW'(1);
      used_r    <= '0;
      upeak_r   <= '0;
      endm_r    <= '0;
      fbytes_r  <= BW'(HEAP_BYTES);
      clr_idx_r <= '0;
      merging_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BASE_ADDRESS: base_r  <= cfg_data;
          CFG_LARGE_START:  large_r <= cfg_data[LSTART_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.accept) merging_r <= 1'b0;
      if (cmd.ev) begin
        if (!hdr_ok) begin
          fail_r <= fail_r + 1'b1;
        end else if (h_used) begin
          merging_r <= 1'b0;
        end else if (merging_r) begin
          blocks_r <= (blocks_r == '0) ? '0 : blocks_r - 1'b1;
          freen_r  <= (freen_r == '0) ? '0 : freen_r - 1'b1;
        end else begin
          merging_r <= 1'b1;
        end
      end
      if (cmd.fin) begin
        if (need_split) begin
          blocks_r <= blocks_inc;
          if (blocks_inc > bpeak_r) bpeak_r <= blocks_inc;
        end else begin
          freen_r <= (freen_r == '0) ? '0 : freen_r - 1'b1;
        end
        used_r   <= used_new;
        fbytes_r <= (taken > fbytes_r) ? '0 : fbytes_r - taken;
        if (top > (BW + 1)'(endm_r)) endm_r <= top[BW-1:0];
        if (used_new > upeak_r) upeak_r <= used_new;
      end
      if (cmd.free_wr) begin
        freen_r  <= (freen_r >= CW'(HEAP_WORDS)) ? CW'(HEAP_WORDS) : freen_r + 1'b1;
        used_r   <= (BW'(h_size) > used_r) ? '0 : used_r - BW'(h_size);
        fbytes_r <= (fb_sum > (BW + 1)'(HEAP_BYTES)) ? BW'(HEAP_BYTES) : fb_sum[BW-1:0];
        if (free_off_r < ADDR_W'(small_r)) small_r <= BW'(free_off_r);
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r     <= in_mode;
      needed_r   <= needed_a;
      pos_r      <= PW'(start_a >> 2);
      free_off_r <= in_free_address - base_r - ADDR_W'(4);
    end
    if (cmd.rd) oob_r <= (pos_r >= PW'(HEAP_WORDS));
    if (cmd.ev) begin
      if (!hdr_ok) begin
        ok_r   <= 1'b0;
        addr_r <= '0;
      end else begin
        if (!h_used) begin
          if (merging_r) begin
            csize_r <= sum;
          end else begin
            chosen_r <= pos_r[AW-1:0];
            csize_r  <= BW'(h_size);
          end
        end
        pos_r <= pos_r + PW'(h_size >> 2);
      end
    end
    if (cmd.fin) begin
      ok_r   <= 1'b1;
      addr_r <= base_r + ADDR_W'({chosen_r, 2'b00}) + ADDR_W'(4);
    end
    if (cmd.free_rd) begin
      ok_r   <= 1'b0;
      addr_r <= '0;
    end
    if (cmd.free_wr) ok_r <= 1'b1;
    if (cmd.load_out) begin
      o_ok_r     <= ok_r;
      o_addr_r   <= addr_r;
      o_fail_r   <= fail_r;
      o_blocks_r <= blocks_r;
      o_freen_r  <= freen_r;
      o_bpeak_r  <= bpeak_r;
      o_used_r   <= used_r;
      o_upeak_r  <= upeak_r;
      o_endm_r   <= endm_r;
      o_fbytes_r <= fbytes_r;
    end
  end

  assign out_ok               = o_ok_r;
  assign out_address          = o_addr_r;
  assign out_failure_count    = o_fail_r;
  assign out_block_total      = CNT_OUT_W'(o_blocks_r);
  assign out_free_blocks      = CNT_OUT_W'(o_freen_r);
  assign out_peak_block_total = CNT_OUT_W'(o_bpeak_r);
  assign out_bytes_used       = BYTE_OUT_W'(o_used_r);
  assign out_peak_bytes_used  = BYTE_OUT_W'(o_upeak_r);
  assign out_high_water       = BYTE_OUT_W'(o_endm_r);
  assign out_bytes_free       = BYTE_OUT_W'(o_fbytes_r);

endmodule

// ----- tb/sv/first_fit_heap_allocator_test.sv -----
// Self-checking testbench for first_fit_heap_allocator: directed table, then random
// allocate/free traffic, each result checked against an in-bench heap predictor.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int HEAP = 4096;
  localparam int WORDS = HEAP / 4;
  localparam int SMALL = 16;
  localparam int LIMIT = 20000000;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [15:0] failure_count;
    logic [10:0] block_total;
    logic [10:0] free_blocks;
    logic [12:0] bytes_used;
    logic [12:0] peak_bytes_used;
    logic [10:0] peak_block_total;
    logic [12:0] high_water;
    logic [12:0] bytes_free;
  } heap_result_t;

  typedef struct {
    logic        mode;
    logic [11:0] size;
    logic [31:0] faddr;
    logic        has_exp;
    logic        exp_ok;
    logic [31:0] exp_addr;
  } heap_req_t;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready, in_mode = 0;
  logic [11:0] in_alloc_size = '0;
  logic [31:0] in_free_address = '0;
  logic out_valid, out_ready = 0;
  heap_result_t got;

  first_fit_heap_allocator dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_mode, .in_alloc_size, .in_free_address,
    .out_valid, .out_ready,
    .out_ok(got.ok), .out_address(got.address), .out_failure_count(got.failure_count),
    .out_block_total(got.block_total), .out_free_blocks(got.free_blocks),
    .out_bytes_used(got.bytes_used), .out_peak_bytes_used(got.peak_bytes_used),
    .out_peak_block_total(got.peak_block_total), .out_high_water(got.high_water),
    .out_bytes_free(got.bytes_free)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  logic [31:0] hdr [0:WORDS];
  logic [31:0] m_base, m_lstart, m_small, m_fail, m_blocks, m_free, m_used;
  logic [31:0] m_used_pk, m_blocks_pk, m_end, m_free_bytes;

  heap_result_t expected_q [$];
  heap_req_t dir_q [$];
  logic [31:0] live_addrs [$];
  int errors = 0;
  int cycles = 0;
  bit out_busy = 1;

  function automatic logic [31:0] sat_add(logic [31:0] a, b, mx);
    return (a >= mx || b > mx - a) ? mx : a + b;
  endfunction

  function automatic logic [31:0] sat_sub(logic [31:0] a, b);
    return (b > a) ? 0 : a - b;
  endfunction

  function automatic logic [31:0] hdr_at(logic [31:0] idx);
    logic [31:0] h, sz;
    if (idx >= WORDS) return 0;
    h = hdr[idx];
    sz = h & 32'h7FFF_FFFF;
    if (sz == 0 || sz[1:0] != 0 || sz > HEAP - idx * 4) return 0;
    return h;
  endfunction

  task automatic heap_reset();
    for (int i = 0; i <= WORDS; i++) hdr[i] = 0;
    hdr[0] = HEAP;
    m_base = 0; m_lstart = 0; m_small = 0; m_fail = 0;
    m_blocks = 1; m_free = 1; m_used = 0; m_used_pk = 0; m_blocks_pk = 1;
    m_end = 0; m_free_bytes = HEAP;
  endtask

  function automatic heap_result_t heap_step(logic mode, logic [11:0] size,
                                             logic [31:0] faddr);
    heap_result_t r;
    logic [31:0] need, pos, chosen, csize, h, sz, taken, top, off;
    bit merging, found;
    r = '0;
    chosen = 0; csize = 0; merging = 0; found = 0;
    if (mode == MODE_ALLOC) begin
      need = ({20'd0, size} + 7) & ~32'd3;
      pos = ((need > SMALL) ? m_lstart : m_small) >> 2;
      while (!found) begin
        h = hdr_at(pos);
        if (h == 0) break;
        sz = h & 32'h7FFF_FFFF;
        if (h[31]) merging = 0;
        else if (merging) begin
          m_blocks = sat_sub(m_blocks, 1);
          m_free = sat_sub(m_free, 1);
          csize += sz;
          hdr[chosen] = csize;
          if (need <= csize) found = 1;
        end else begin
          chosen = pos; csize = sz; merging = 1;
          if (need <= csize) found = 1;
        end
        pos += sz >> 2;
      end
      if (!found) m_fail = (m_fail + 1) & 32'hFFFF;
      else begin
        if (csize - need < 4) begin
          taken = csize;
          m_free = sat_sub(m_free, 1);
          hdr[chosen] = csize | 32'h8000_0000;
        end else begin
          taken = need;
          hdr[chosen + (need >> 2)] = csize - need;
          hdr[chosen] = need | 32'h8000_0000;
          m_blocks = sat_add(m_blocks, 1, WORDS);
          if (m_blocks > m_blocks_pk) m_blocks_pk = m_blocks;
        end
        m_used = sat_add(m_used, taken, HEAP);
        m_free_bytes = sat_sub(m_free_bytes, taken);
        top = chosen * 4 + taken;
        if (top > m_end) m_end = top;
        if (m_used > m_used_pk) m_used_pk = m_used;
        r.ok = 1;
        r.address = m_base + chosen * 4 + 4;
      end
    end else begin
      off = faddr - m_base - 4;
      if (off[1:0] == 0 && off < HEAP) begin
        sz = hdr[off >> 2] & 32'h7FFF_FFFF;
        hdr[off >> 2] = sz;
        m_free = sat_add(m_free, 1, WORDS);
        m_used = sat_sub(m_used, sz);
        m_free_bytes = sat_add(m_free_bytes, sz, HEAP);
        if (off < m_small) m_small = off;
        r.ok = 1;
      end
    end
    r.failure_count = m_fail[15:0];
    r.block_total = m_blocks[10:0];
    r.free_blocks = m_free[10:0];
    r.bytes_used = m_used[12:0];
    r.peak_bytes_used = m_used_pk[12:0];
    r.peak_block_total = m_blocks_pk[10:0];
    r.high_water = m_end[12:0];
    r.bytes_free = m_free_bytes[12:0];
    return r;
  endfunction

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
    if (idx == CFG_BASE_ADDRESS) m_base = val;
    else m_lstart = val & 32'hFFF;
  endtask

  // valid stays up after the accept; pause or drain drops it
  task automatic send_item(logic mode, logic [11:0] size, logic [31:0] faddr);
    heap_result_t r;
    in_valid <= 1; in_mode <= mode; in_alloc_size <= size; in_free_address <= faddr;
    do @(posedge clk); while (!in_ready);
    r = heap_step(mode, size, faddr);
    expected_q.push_back(r);
    if (mode == MODE_ALLOC && r.ok) live_addrs.push_back(r.address);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    heap_result_t e;
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (dir_q.size() != 0) begin
          if (dir_q[0].has_exp && (got.ok !== dir_q[0].exp_ok ||
              got.address !== dir_q[0].exp_addr)) begin
            $display("%0t: table row exp ok=%0d addr=%h got ok=%0d addr=%h", $time,
                     dir_q[0].exp_ok, dir_q[0].exp_addr, got.ok, got.address);
            errors++;
          end
          void'(dir_q.pop_front());
        end
        if (got.ok !== e.ok) begin
          $display("%0t: ok exp %0d got %0d", $time, e.ok, got.ok); errors++;
        end
        if (got.address !== e.address) begin
          $display("%0t: address exp %h got %h", $time, e.address, got.address);
          errors++;
        end
        if (got.failure_count !== e.failure_count) begin
          $display("%0t: failure_count exp %0d got %0d", $time, e.failure_count,
                   got.failure_count); errors++;
        end
        if (got.block_total !== e.block_total) begin
          $display("%0t: block_total exp %0d got %0d", $time, e.block_total,
                   got.block_total); errors++;
        end
        if (got.free_blocks !== e.free_blocks) begin
          $display("%0t: free_blocks exp %0d got %0d", $time, e.free_blocks,
                   got.free_blocks); errors++;
        end
        if (got.bytes_used !== e.bytes_used) begin
          $display("%0t: bytes_used exp %0d got %0d", $time, e.bytes_used,
                   got.bytes_used); errors++;
        end
        if (got.peak_bytes_used !== e.peak_bytes_used) begin
          $display("%0t: peak_bytes_used exp %0d got %0d", $time, e.peak_bytes_used,
                   got.peak_bytes_used); errors++;
        end
        if (got.peak_block_total !== e.peak_block_total) begin
          $display("%0t: peak_block_total exp %0d got %0d", $time, e.peak_block_total,
                   got.peak_block_total); errors++;
        end
        if (got.high_water !== e.high_water) begin
          $display("%0t: high_water exp %0d got %0d", $time, e.high_water,
                   got.high_water); errors++;
        end
        if (got.bytes_free !== e.bytes_free) begin
          $display("%0t: bytes_free exp %0d got %0d", $time, e.bytes_free,
                   got.bytes_free); errors++;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("[first_fit_heap_allocator] ERROR");
      $finish;
    end
  end

  // receiver stalls; stretches with ready held high
  initial begin
    int n;
    while (out_busy) begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
      n = gap();
      out_ready <= (n == 0);
      if (n != 0) begin
        repeat (n) @(negedge clk);
        out_ready <= 1;
      end
    end
  end

  initial begin
    heap_req_t t [$];
    logic [31:0] a;
    int k;
    heap_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: {mode, size, free address, checked, ok, address}
    t.push_back('{MODE_ALLOC, 12'd0,    32'd0,    1, 1, 32'd4});
    t.push_back('{MODE_ALLOC, 12'd12,   32'd0,    1, 1, 32'd8});
    t.push_back('{MODE_ALLOC, 12'd13,   32'd0,    1, 1, 32'd24});
    t.push_back('{MODE_ALLOC, 12'd4092, 32'd0,    1, 0, 32'd0});
    t.push_back('{MODE_FREE,  12'd0,    32'd4,    1, 1, 32'd0});
    t.push_back('{MODE_FREE,  12'd0,    32'd8,    1, 1, 32'd0});
    t.push_back('{MODE_FREE,  12'd0,    32'd8,    0, 0, 32'd0}); // double free
    t.push_back('{MODE_FREE,  12'd0,    32'd6,    1, 0, 32'd0}); // unaligned
    t.push_back('{MODE_FREE,  12'd0,    32'd0,    1, 0, 32'd0}); // below heap
    t.push_back('{MODE_FREE,  12'd0,    32'd4100, 1, 0, 32'd0}); // past end
    t.push_back('{MODE_FREE,  12'hFFF,  32'hFFFF_FFFF, 1, 0, 32'd0});
    t.push_back('{MODE_ALLOC, 12'd1,    32'd0,    0, 0, 32'd0}); // merges freed pair
    t.push_back('{MODE_ALLOC, 12'd100,  32'd0,    0, 0, 32'd0});
    t.push_back('{MODE_FREE,  12'd0,    32'd24,   0, 0, 32'd0});
    t.push_back('{MODE_ALLOC, 12'd2000, 32'd0,    0, 0, 32'd0});
    t.push_back('{MODE_ALLOC, 12'd2000, 32'd0,    0, 0, 32'd0});
    t.push_back('{MODE_FREE,  12'd0,    32'd2000, 0, 0, 32'd0}); // stray free
    t.push_back('{MODE_ALLOC, 12'd8,    32'd0,    0, 0, 32'd0});
    foreach (t[i]) begin
      dir_q.push_back(t[i]);
      send_item(t[i].mode, t[i].size, t[i].faddr);
      pause(gap());
    end
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFC); write_reg(CFG_LARGE_START, 0); end
        1: begin write_reg(CFG_BASE_ADDRESS, 32'h1000_0000);
                 write_reg(CFG_LARGE_START, 12'hFFC); end
        2: write_reg(CFG_LARGE_START, 12'hFFF);
        3: write_reg(CFG_LARGE_START, 12'd1024);
        default: begin
          write_reg(CFG_BASE_ADDRESS, $urandom() & ~32'd3);
          write_reg(CFG_LARGE_START, $urandom_range(0, 12'hFFF));
        end
      endcase
      live_addrs.delete(); // old addresses are relative to the prior base
      for (int i = 0; i < 150; i++) begin
        k = $urandom_range(0, 99);
        if (k < 45) begin
          a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12'hFFF)
                                          : $urandom_range(0, 64);
          send_item(MODE_ALLOC, a[11:0], $urandom());
        end else if (k < 85 && live_addrs.size() != 0) begin
          a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
          send_item(MODE_FREE, 12'($urandom()), a);
        end else if (k < 92) begin
          send_item(MODE_FREE, 12'($urandom()),
                    m_base + 4 * $urandom_range(0, WORDS - 1) + 4);
        end else begin
          send_item(MODE_FREE, 12'($urandom()), $urandom());
        end
        pause(gap());
      end
      drain();
    end

    out_busy = 0;
    if (errors == 0) $display("[first_fit_heap_allocator] OK");
    else $display("[first_fit_heap_allocator] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_test.sv
